/* rtl/tqpas_pkg.sv */
package tqpas_pkg;

    localparam int STORE_DEPTH = 64;
    localparam int AW = $clog2(STORE_DEPTH);
    localparam int CW = $clog2(STORE_DEPTH + 1);

    localparam int TAG_W = 16;
    localparam int Q_W = 11;
    localparam int ENTRY_W = TAG_W + Q_W;
    localparam int NUM_W = 41;
    localparam int DEN_W = 25;
    localparam int DCNT_W = $clog2(NUM_W);

    localparam logic [Q_W-1:0] Q_MAX = 11'd1280;
    localparam logic [Q_W-1:0] Q_HEAD = 11'd896;
    localparam logic [Q_W-1:0] Q_REJECT = 11'd768;
    localparam logic [Q_W-1:0] Q_FILTER = 11'd512;
    localparam logic [DEN_W-1:0] DEN_BASE = 25'd51200;

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    localparam logic [1:0] ST_ADMIT = 2'd0;
    localparam logic [1:0] ST_DROP = 2'd1;
    localparam logic [1:0] ST_DELIVER = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    localparam logic [1:0] CLS_ROUTING = 2'd0;
    localparam logic [1:0] CLS_EXPERIMENT = 2'd1;

    localparam logic [1:0] REG_NODE = 2'd0;
    localparam logic [1:0] REG_LIMIT = 2'd1;
    localparam logic [1:0] REG_ALPHA = 2'd2;
    localparam logic [1:0] REG_BETA = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_ND,
        S_DIV,
        S_DECIDE,
        S_INS_START,
        S_INS_STEP,
        S_DEQ_RD,
        S_DEQ_FIN,
        S_OUT
    } t_state;

    typedef struct packed {
        logic accept;
        logic mul;
        logic nd;
        logic div_step;
        logic decide;
        logic ins_start;
        logic ins_step;
        logic deq_pick;
        logic deq_fin;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic op;
        logic div_last;
        logic drop;
        logic ins_last;
        logic deq_empty;
        logic out_busy;
    } t_sts;

    function automatic logic [AW-1:0] f_slot(input logic [AW-1:0] hd, input logic [CW-1:0] k);
        logic [CW:0] s;
        s = {(CW + 1 - AW)'(0), hd} + {1'b0, k};
        if (s >= (CW + 1)'(STORE_DEPTH)) begin
            s = s - (CW + 1)'(STORE_DEPTH);
        end
        return s[AW-1:0];
    endfunction

endpackage

/* rtl/tqpas_ctrl.sv */
module tqpas_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  tqpas_pkg::t_sts   i_sts,
    output tqpas_pkg::t_cmd   o_cmd
);

    tqpas_pkg::t_state r_state;
    tqpas_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tqpas_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_in_ready = 1'b0;
        case (r_state)
            tqpas_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state = tqpas_pkg::S_MUL;
                end
            end
            tqpas_pkg::S_MUL: begin
                if (i_sts.op == tqpas_pkg::OP_DEQ) begin
                    n_state = tqpas_pkg::S_DEQ_RD;
                end else begin
                    o_cmd.mul = 1'b1;
                    n_state = tqpas_pkg::S_ND;
                end
            end
            tqpas_pkg::S_ND: begin
                o_cmd.nd = 1'b1;
                n_state = tqpas_pkg::S_DIV;
            end
            tqpas_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = tqpas_pkg::S_DECIDE;
                end
            end
            tqpas_pkg::S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state = tqpas_pkg::S_INS_START;
            end
            tqpas_pkg::S_INS_START: begin
                if (i_sts.drop) begin
                    n_state = tqpas_pkg::S_OUT;
                end else begin
                    o_cmd.ins_start = 1'b1;
                    n_state = tqpas_pkg::S_INS_STEP;
                end
            end
            tqpas_pkg::S_INS_STEP: begin
                o_cmd.ins_step = 1'b1;
                if (i_sts.ins_last) begin
                    n_state = tqpas_pkg::S_OUT;
                end
            end
            tqpas_pkg::S_DEQ_RD: begin
                o_cmd.deq_pick = 1'b1;
                if (i_sts.deq_empty) begin
                    n_state = tqpas_pkg::S_OUT;
                end else begin
                    n_state = tqpas_pkg::S_DEQ_FIN;
                end
            end
            tqpas_pkg::S_DEQ_FIN: begin
                o_cmd.deq_fin = 1'b1;
                n_state = tqpas_pkg::S_OUT;
            end
            tqpas_pkg::S_OUT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state = tqpas_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tqpas_pkg::S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/tqpas_datapath.sv */
module tqpas_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [1:0]        i_cfg_index,
    input  logic [15:0]       i_cfg_data,
    input  logic              i_op,
    input  logic [47:0]       i_in_data,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [31:0]       o_out_data,
    output logic [1:0]        o_out_user,
    input  tqpas_pkg::t_cmd   i_cmd,
    output tqpas_pkg::t_sts   o_sts
);

    logic [15:0] r_node;
    logic [6:0]  r_limit;
    logic [15:0] r_alpha;
    logic [15:0] r_beta;

    logic                         r_op;
    logic [tqpas_pkg::TAG_W-1:0]  r_tag;
    logic                         r_sel;
    logic [7:0]                   r_hops;
    logic [1:0]                   r_stat;
    logic [23:0]                  r_prod_a;
    logic [23:0]                  r_prod_b;
    logic [tqpas_pkg::NUM_W-1:0]  r_num;
    logic [tqpas_pkg::DEN_W-1:0]  r_den;
    logic [tqpas_pkg::DEN_W-1:0]  r_rem;
    logic [tqpas_pkg::NUM_W-1:0]  r_quo;
    logic [tqpas_pkg::DCNT_W-1:0] r_dcnt;
    logic [tqpas_pkg::Q_W-1:0]    r_q;
    logic                         r_drop;
    logic [1:0]                   r_res;
    logic [tqpas_pkg::CW-1:0]     r_k;

    logic [tqpas_pkg::ENTRY_W-1:0] mem_l [tqpas_pkg::STORE_DEPTH];
    logic [tqpas_pkg::ENTRY_W-1:0] mem_f [tqpas_pkg::STORE_DEPTH];
    logic [tqpas_pkg::ENTRY_W-1:0] r_rd_l;
    logic [tqpas_pkg::ENTRY_W-1:0] r_rd_f;
    logic [tqpas_pkg::AW-1:0]      r_hd_l;
    logic [tqpas_pkg::AW-1:0]      r_hd_f;
    logic [tqpas_pkg::CW-1:0]      r_cnt_l;
    logic [tqpas_pkg::CW-1:0]      r_cnt_f;
    logic                          r_turn;

    logic        r_out_vld;
    logic [31:0] r_out_data;
    logic [1:0]  r_out_user;

    logic                          in_local;
    logic [1:0]                    in_stat;
    logic [24:0]                   sum_a;
    logic [tqpas_pkg::DEN_W:0]     rem_sh;
    logic                          q_bit;
    logic [tqpas_pkg::Q_W-1:0]     q_cap;
    logic [tqpas_pkg::CW:0]        occ;
    logic [9:0]                    occ3;
    logic                          drop_now;
    logic [tqpas_pkg::CW-1:0]      cnt_cur;
    logic [tqpas_pkg::AW-1:0]      hd_cur;
    logic [tqpas_pkg::ENTRY_W-1:0] rd_cur;
    logic [tqpas_pkg::ENTRY_W-1:0] new_entry;
    logic                          shift;
    logic                          ins_last;
    logic                          deq_sel;
    logic                          deq_empty;
    logic [tqpas_pkg::AW-1:0]      rd_addr;
    logic [tqpas_pkg::AW-1:0]      wr_addr;
    logic [tqpas_pkg::ENTRY_W-1:0] wr_data;

    assign in_local = (i_in_data[31:16] == r_node);
    assign in_stat = (i_in_data[33:32] == tqpas_pkg::CLS_ROUTING) ? 2'd3 :
                     (i_in_data[33:32] == tqpas_pkg::CLS_EXPERIMENT) ? 2'd2 : 2'd1;

    assign sum_a = {1'b0, r_prod_a} + 25'({r_stat, 8'd0});
    assign rem_sh = {r_rem, r_num[tqpas_pkg::NUM_W-1]};
    assign q_bit = (rem_sh >= {1'b0, r_den});

    assign q_cap = (r_quo > tqpas_pkg::NUM_W'(tqpas_pkg::Q_MAX)) ? tqpas_pkg::Q_MAX :
                   r_quo[tqpas_pkg::Q_W-1:0];
    assign occ = {1'b0, r_cnt_l} + {1'b0, r_cnt_f};
    assign occ3 = 10'(occ) + 10'({occ, 1'b0});

    assign cnt_cur = r_sel ? r_cnt_f : r_cnt_l;
    assign hd_cur = r_sel ? r_hd_f : r_hd_l;
    assign rd_cur = r_sel ? r_rd_f : r_rd_l;
    assign new_entry = {r_q, r_tag};

    always_comb begin
        drop_now = 1'b0;
        if (10'({r_limit, 1'b0}) < occ3) begin
            if ((q_cap <= tqpas_pkg::Q_REJECT) ||
                (10'(occ) + 10'd1 >= 10'(r_limit))) begin
                drop_now = 1'b1;
            end
        end else if (10'(r_limit) < occ3 + 10'd3) begin
            if (q_cap < tqpas_pkg::Q_FILTER) begin
                drop_now = 1'b1;
            end
        end
        if (cnt_cur == tqpas_pkg::CW'(tqpas_pkg::STORE_DEPTH)) begin
            drop_now = 1'b1;
        end
    end

    assign shift = (r_q > tqpas_pkg::Q_HEAD) ?
                   (rd_cur[tqpas_pkg::ENTRY_W-1:tqpas_pkg::TAG_W] <= r_q) :
                   (rd_cur[tqpas_pkg::ENTRY_W-1:tqpas_pkg::TAG_W] < r_q);
    assign ins_last = (r_k == '0) || !shift;

    assign deq_sel = r_turn ? (r_cnt_f != '0) : (r_cnt_l == '0);
    assign deq_empty = (r_cnt_l == '0) && (r_cnt_f == '0);

    always_comb begin
        rd_addr = deq_sel ? r_hd_f : r_hd_l;
        if (i_cmd.ins_start) begin
            rd_addr = tqpas_pkg::f_slot(hd_cur, cnt_cur - tqpas_pkg::CW'(1));
        end else if (i_cmd.ins_step) begin
            rd_addr = tqpas_pkg::f_slot(hd_cur, r_k - tqpas_pkg::CW'(2));
        end
    end

    assign wr_addr = tqpas_pkg::f_slot(hd_cur, r_k);
    assign wr_data = ins_last ? new_entry : rd_cur;

    always_ff @(posedge i_clk) begin
        r_rd_l <= mem_l[rd_addr];
        if (i_cmd.ins_step && !r_sel) begin
            mem_l[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_f <= mem_f[rd_addr];
        if (i_cmd.ins_step && r_sel) begin
            mem_f[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node <= '0;
            r_limit <= 7'd50;
            r_alpha <= 16'd256;
            r_beta <= 16'd256;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                tqpas_pkg::REG_NODE:  r_node <= i_cfg_data;
                tqpas_pkg::REG_LIMIT: r_limit <= i_cfg_data[6:0];
                tqpas_pkg::REG_ALPHA: r_alpha <= i_cfg_data;
                tqpas_pkg::REG_BETA:  r_beta <= i_cfg_data;
                default: r_node <= r_node;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op <= i_op;
            r_tag <= i_in_data[15:0];
            r_sel <= !in_local;
            r_hops <= in_local ? 8'd1 : i_in_data[41:34];
            r_stat <= in_stat;
            r_prod_b <= {8'd0, r_beta} * {16'd0, i_in_data[41:34]};
        end
        if (i_cmd.mul) begin
            r_prod_a <= {8'd0, r_alpha} * {16'd0, r_hops};
        end
        if (i_cmd.nd) begin
            r_num <= ({16'd0, sum_a} << 15) + ({16'd0, sum_a} << 14) +
                     ({16'd0, sum_a} << 11);
            r_den <= tqpas_pkg::DEN_BASE + {1'b0, r_prod_b};
            r_rem <= '0;
            r_quo <= '0;
            r_dcnt <= tqpas_pkg::DCNT_W'(tqpas_pkg::NUM_W - 1);
        end
        if (i_cmd.div_step) begin
            r_num <= {r_num[tqpas_pkg::NUM_W-2:0], 1'b0};
            r_rem <= q_bit ? tqpas_pkg::DEN_W'(rem_sh - {1'b0, r_den}) :
                     rem_sh[tqpas_pkg::DEN_W-1:0];
            r_quo <= {r_quo[tqpas_pkg::NUM_W-2:0], q_bit};
            r_dcnt <= r_dcnt - 1'b1;
        end
        if (i_cmd.decide) begin
            r_q <= q_cap;
            r_drop <= drop_now;
            r_res <= drop_now ? tqpas_pkg::ST_DROP : tqpas_pkg::ST_ADMIT;
        end
        if (i_cmd.ins_start) begin
            r_k <= cnt_cur;
        end
        if (i_cmd.ins_step) begin
            r_k <= r_k - 1'b1;
        end
        if (i_cmd.deq_pick) begin
            r_sel <= deq_empty ? 1'b0 : deq_sel;
            if (deq_empty) begin
                r_res <= tqpas_pkg::ST_EMPTY;
                r_tag <= '0;
                r_q <= '0;
            end
        end
        if (i_cmd.deq_fin) begin
            r_res <= tqpas_pkg::ST_DELIVER;
            r_tag <= rd_cur[tqpas_pkg::TAG_W-1:0];
            r_q <= rd_cur[tqpas_pkg::ENTRY_W-1:tqpas_pkg::TAG_W];
        end
        if (i_cmd.out_load) begin
            r_out_data <= {4'd0, r_sel, r_q, r_tag};
            r_out_user <= r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hd_l <= '0;
            r_hd_f <= '0;
            r_cnt_l <= '0;
            r_cnt_f <= '0;
            r_turn <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cmd.ins_step && ins_last) begin
                if (r_sel) begin
                    r_cnt_f <= r_cnt_f + 1'b1;
                end else begin
                    r_cnt_l <= r_cnt_l + 1'b1;
                end
            end
            if (i_cmd.deq_fin) begin
                if (r_sel) begin
                    r_cnt_f <= r_cnt_f - 1'b1;
                    r_hd_f <= tqpas_pkg::f_slot(r_hd_f, tqpas_pkg::CW'(1));
                end else begin
                    r_cnt_l <= r_cnt_l - 1'b1;
                    r_hd_l <= tqpas_pkg::f_slot(r_hd_l, tqpas_pkg::CW'(1));
                end
                if (r_sel == r_turn) begin
                    r_turn <= !r_turn;
                end
            end
            if (i_cmd.out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data = r_out_data;
    assign o_out_user = r_out_user;

    assign o_sts.op = r_op;
    assign o_sts.div_last = (r_dcnt == '0);
    assign o_sts.drop = r_drop;
    assign o_sts.ins_last = ins_last;
    assign o_sts.deq_empty = deq_empty;
    assign o_sts.out_busy = r_out_vld && !i_out_ready;

endmodule

/* rtl/two_queue_priority_admission_scheduler.sv */
// Admission scheduler with a local and a forwarded store of 64 entries each, kept in priority
// order as circular buffers. A dequeue word reads the head of the chosen store and then frees
// that slot; when both stores are empty, the freeing step is skipped. An enqueue word first
// gets its priority from the bit-serial divider that produces one quotient bit per cycle over
// 41 bits, then is inserted into its store (a dropped word skips the insert), one entry moved
// per cycle through the store's single write port, and then goes to the output register. One word
// is in work at a time; the next is taken in the cycle after the result is loaded, and a
// finished result waits in the output register while the next is taken. A result that finds
// the previous one still untaken waits until it is taken.
module two_queue_priority_admission_scheduler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // packet_tag, source_address, packet_class, hop_count, zero fill
    input  logic [47:0] s_axis_tdata,
    // operation
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_tag, out_priority, store_select, zero fill
    output logic [31:0] m_axis_tdata,
    // status
    output logic [1:0]  m_axis_tuser
);

    tqpas_pkg::t_cmd cmd;
    tqpas_pkg::t_sts sts;

    tqpas_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    tqpas_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_op        (s_axis_tuser),
        .i_in_data   (s_axis_tdata),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_user  (m_axis_tuser),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

`ifndef SYNTHESIS
    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second word taken while one is in work");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == tqpas_pkg::ST_EMPTY) |-> (m_axis_tdata == '0))
        else $error("empty result carries data");

    a_prio_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[26:16] <= tqpas_pkg::Q_MAX))
        else $error("priority above cap");
`endif

endmodule
